/* hw/rtl/alu4_pkg.sv */
// Shared types and constants for the four-operation unsigned ALU.
package alu4_pkg;

  localparam int WIDTH   = 32;             // significant operand bits, 8..32
  localparam int OPND_W  = 32;             // operand field width
  localparam int RES_W   = 64;             // result field width
  localparam int Q_DEPTH = 4;              // front-to-back queue entries
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NEG     = 2'd1,
    ST_DIV0    = 2'd2,
    ST_INEXACT = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [OPND_W-1:0] operand_a;
    logic [OPND_W-1:0] operand_b;
  } req_t;

  typedef struct packed {
    logic [RES_W-1:0] result;
    logic [1:0]       status;
  } rsp_t;

  // Classified command handed from front to back.
  typedef struct packed {
    op_t              op;
    logic [WIDTH-1:0] a;
    logic [WIDTH-1:0] b;
    logic             neg;   // a < b
    logic             dz;    // b == 0
  } cmd_t;

endpackage

/* hw/rtl/alu4_front.sv */
// Front end: accepts requests, masks operands and classifies them.
module alu4_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  alu4_pkg::req_t req,
  output logic          cmd_valid,
  input  logic          cmd_ready,
  output alu4_pkg::cmd_t cmd
);
  import alu4_pkg::*;

  logic [WIDTH-1:0] a_m;
  logic [WIDTH-1:0] b_m;

  assign a_m       = req.operand_a[WIDTH-1:0];
  assign b_m       = req.operand_b[WIDTH-1:0];
  assign req_ready = !cmd_valid || cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (req_ready) begin
      cmd_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      cmd.op  <= op_t'(req.op);
      cmd.a   <= a_m;
      cmd.b   <= b_m;
      cmd.neg <= (a_m < b_m);
      cmd.dz  <= (b_m == '0);
    end
  end

endmodule

/* hw/rtl/alu4_queue.sv */
// Short command queue between front and back.
module alu4_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  alu4_pkg::cmd_t wdata,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output alu4_pkg::cmd_t rdata
);
  import alu4_pkg::*;

  cmd_t            mem [Q_DEPTH];
  logic [Q_AW-1:0] wptr;
  logic [Q_AW-1:0] rptr;
  logic [Q_CW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign full    = (count == Q_CW'(Q_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= wptr + Q_AW'(1);
      end
      if (do_pop) begin
        rptr <= rptr + Q_AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + Q_CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - Q_CW'(1);
      end
    end
  end

endmodule

/* hw/rtl/alu4_back.sv */
// Back end: add/sub/mul stage, bit-per-stage divider, output register.
module alu4_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  output logic           q_pop,
  input  alu4_pkg::cmd_t cmd,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output alu4_pkg::rsp_t rsp
);
  import alu4_pkg::*;

  typedef struct packed {
    op_t              op;
    status_t          status;
    logic [RES_W-1:0] result;
    logic [WIDTH-1:0] divisor;
    logic [WIDTH-1:0] rem;
    logic [WIDTH-1:0] aq;      // dividend bits shift out, quotient bits shift in
  } stage_t;

  // One restoring-division step.
  function automatic stage_t div_step(input stage_t s);
    stage_t         o;
    logic [WIDTH:0] cur;
    logic [WIDTH:0] diff;
    o    = s;
    cur  = {s.rem, s.aq[WIDTH-1]};
    diff = cur - {1'b0, s.divisor};
    if (!diff[WIDTH]) begin
      o.rem = diff[WIDTH-1:0];
      o.aq  = {s.aq[WIDTH-2:0], 1'b1};
    end else begin
      o.rem = cur[WIDTH-1:0];
      o.aq  = {s.aq[WIDTH-2:0], 1'b0};
    end
    return o;
  endfunction

  stage_t           stg [WIDTH+1];
  logic [WIDTH:0]   vld;
  logic             adv;
  stage_t           s0;
  logic [WIDTH:0]   sum;
  logic [2*WIDTH-1:0] prod;
  rsp_t             rsp_next;

  assign adv   = !rsp_valid || rsp_ready;
  assign q_pop = adv && !q_empty;
  assign sum   = {1'b0, cmd.a} + {1'b0, cmd.b};
  assign prod  = (2*WIDTH)'(cmd.a) * (2*WIDTH)'(cmd.b);

  always_comb begin
    s0         = '0;
    s0.op      = cmd.op;
    s0.status  = ST_OK;
    s0.divisor = cmd.b;
    s0.aq      = cmd.a;
    unique case (cmd.op)
      OP_ADD: s0.result = RES_W'(sum);
      OP_SUB: begin
        if (cmd.neg) begin
          s0.status = ST_NEG;
        end else begin
          s0.result = RES_W'(cmd.a - cmd.b);
        end
      end
      OP_MUL: s0.result = RES_W'(prod);
      OP_DIV: begin
        if (cmd.dz) begin
          s0.status = ST_DIV0;
        end
      end
      default: s0.result = '0;
    endcase
  end

  always_comb begin
    rsp_next.result = stg[WIDTH].result;
    rsp_next.status = stg[WIDTH].status;
    if (stg[WIDTH].op == OP_DIV && stg[WIDTH].status == ST_OK) begin
      if (stg[WIDTH].rem != '0) begin
        rsp_next.status = ST_INEXACT;
        rsp_next.result = '0;
      end else begin
        rsp_next.result = RES_W'(stg[WIDTH].aq);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      rsp_valid <= 1'b0;
    end else if (adv) begin
      vld       <= {vld[WIDTH-1:0], q_pop};
      rsp_valid <= vld[WIDTH];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      stg[0] <= s0;
      for (int k = 0; k < WIDTH; k++) begin
        stg[k+1] <= div_step(stg[k]);
      end
      rsp <= rsp_next;
    end
  end

endmodule

/* hw/rtl/four_op_unsigned_alu_core.sv */
// Four-operation unsigned ALU: add, subtract, multiply, exact divide.
// Throughput: one transfer per cycle unless rsp_ready holds the back pipeline;
//   the divider retires one quotient bit per stage over WIDTH stages, and the
//   whole back pipeline moves as one.
// Reset: synchronous, active high; clears valid flags, queue pointers and the
//   queue count only, no clearing pass.
module four_op_unsigned_alu_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  alu4_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output alu4_pkg::rsp_t rsp
);
  import alu4_pkg::*;

  // front -> queue
  logic cmd_valid;
  logic q_full;
  cmd_t cmd_f;

  // queue -> back
  logic q_empty;
  logic q_pop;
  cmd_t cmd_b;

  // Front masks operands to WIDTH bits and precomputes the compare flags
  // (a < b for subtract, b == 0 for divide), so the back only does math.
  alu4_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .cmd_valid (cmd_valid),
    .cmd_ready (!q_full),
    .cmd       (cmd_f)
  );

  // A few entries of slack so the front keeps taking transfers while the
  // back is held by a stalled consumer.
  alu4_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_valid),
    .wdata (cmd_f),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (cmd_b)
  );

  // Back: sum/difference/product resolved in the first stage, then the
  // division stages, then the output register feeding rsp.
  alu4_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .cmd       (cmd_b),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

/* sim/alu4_result_checker.sv */
// Result checker for the four-operation ALU: request/response monitor, predictor, scoreboard.
`timescale 1ns / 1ps

module alu4_result_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic           req_ready,
  input  alu4_pkg::req_t req,
  input  logic           rsp_valid,
  input  logic           rsp_ready,
  input  alu4_pkg::rsp_t rsp,
  output int             bad_results,
  output int             results_owed
);
  import alu4_pkg::*;

  localparam logic [RES_W-1:0] LANE_MASK = (RES_W'(1) << WIDTH) - 1;

  rsp_t awaited_results[$];

  // Operands are cut to WIDTH bits and widened so sums and products never wrap.
  function automatic rsp_t compute_alu_result(input req_t r);
    logic [RES_W-1:0] a;
    logic [RES_W-1:0] b;
    rsp_t             o;
    a        = RES_W'(r.operand_a) & LANE_MASK;
    b        = RES_W'(r.operand_b) & LANE_MASK;
    o.result = '0;
    o.status = ST_OK;
    case (op_t'(r.op))
      OP_ADD: o.result = a + b;
      OP_SUB: begin
        if (a < b) o.status = ST_NEG;
        else       o.result = a - b;
      end
      OP_MUL: o.result = a * b;
      OP_DIV: begin
        // zero divisor wins over the exactness test
        if (b == '0)           o.status = ST_DIV0;
        else if (a % b != '0)  o.status = ST_INEXACT;
        else                   o.result = a / b;
      end
    endcase
    return o;
  endfunction

  function automatic void note_mismatch(input string what, input rsp_t want, input rsp_t got);
    bad_results++;
    if (bad_results <= 10)
      $display("%0t: %s: expected result=%h status=%0d, got result=%h status=%0d",
               $realtime, what, want.result, want.status, got.result, got.status);
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      awaited_results.delete();
    end else begin
      // responses first: a request accepted this edge cannot be answered at it
      if (rsp_valid && rsp_ready) begin
        if (awaited_results.size() == 0) begin
          note_mismatch("result with no request outstanding", '0, rsp);
        end else begin
          want = awaited_results.pop_front();
          if (rsp.result !== want.result || rsp.status !== want.status)
            note_mismatch("result mismatch", want, rsp);
        end
      end
      if (req_valid && req_ready)
        awaited_results.push_back(compute_alu_result(req));
    end
    results_owed = awaited_results.size();
  end

endmodule

/* sim/four_op_unsigned_alu_core_tb.sv */
// Testbench top for the four-operation ALU: clock, reset, stimulus, sink and verdict.
`timescale 1ns / 1ps

module four_op_unsigned_alu_core_tb;
  import alu4_pkg::*;

  localparam int RANDOM_ITEMS = 1800;
  localparam int HOLD_CYCLES  = 300;   // long sink hold-off, well past pipe + queue depth
  localparam int HOLD_FIRST   = 700;   // random item index where the hold-off starts
  localparam int HOLD_LAST    = 850;   // sender runs back-to-back up to here
  localparam int DRAIN_CYCLES = 60;    // longer than the request-to-response latency, catches stray results

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic rsp_ready = 1'b0;
  req_t req       = '0;
  logic req_ready;
  logic rsp_valid;
  rsp_t rsp;

  int   bad_results;
  int   results_owed;

  // Per-stretch idle ceilings; zero gives runs with no bubbles at all.
  int   send_gap_max = 8;
  int   recv_gap_max = 8;
  logic hold_wanted  = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  four_op_unsigned_alu_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  alu4_result_checker i_check (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_ready    (req_ready),
    .req          (req),
    .rsp_valid    (rsp_valid),
    .rsp_ready    (rsp_ready),
    .rsp          (rsp),
    .bad_results  (bad_results),
    .results_owed (results_owed)
  );

  function automatic req_t make_req(input op_t op, input logic [31:0] a, input logic [31:0] b);
    req_t r;
    r.op        = op;
    r.operand_a = a;
    r.operand_b = b;
    return r;
  endfunction

  // Operand mix: tiny values, near-max values, single bits, shifted and full random.
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 5))
      0:       return $urandom_range(0, 15);
      1:       return 32'hFFFF_FFFF - $urandom_range(0, 15);
      2:       return 32'd1 << $urandom_range(0, 31);
      3:       return $urandom >> $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  // Random request. Subtracts are ordered half the time so both signs of the
  // difference show up; divides are mostly built exact (a = b * q), since
  // random pairs would almost always come out inexact.
  function automatic req_t random_req();
    req_t        r;
    logic [31:0] swap;
    logic [31:0] quot;
    r.op        = op_t'($urandom_range(0, 3));
    r.operand_a = pick_operand();
    r.operand_b = pick_operand();
    case (op_t'(r.op))
      OP_SUB: begin
        if ($urandom_range(0, 1) == 1 && r.operand_a < r.operand_b) begin
          swap        = r.operand_a;
          r.operand_a = r.operand_b;
          r.operand_b = swap;
        end
      end
      OP_DIV: begin
        case ($urandom_range(0, 7))
          0:    r.operand_b = '0;
          1, 2: ;  // leave as drawn, usually inexact
          default: begin
            if (r.operand_b != '0) begin
              quot        = $urandom_range(0, 32'hFFFF_FFFF / r.operand_b);
              r.operand_a = r.operand_b * quot;
            end
          end
        endcase
      end
      default: ;
    endcase
    return r;
  endfunction

  // One request transfer. Called at a falling edge; returns at the falling
  // edge after the transfer, so back-to-back calls keep valid high without
  // a drop in between.
  task automatic offer_request(input req_t r);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    @(posedge clk);
    while (!(req_valid && req_ready)) @(posedge clk);
    @(negedge clk);
  endtask

  // Response sink: random ready stalls per result, quiet stretches every 64
  // results, and one long hold-off so the pipe and queue back up into
  // req_ready.
  initial begin : result_sink
    int   stall;
    int   taken;
    logic hold_done;
    taken     = 0;
    hold_done = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (taken % 64 == 0)
        recv_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
      stall = $urandom_range(0, recv_gap_max);
      if (hold_wanted && !hold_done) begin
        stall     = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (stall > 0) begin
        rsp_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ready <= 1'b1;
      @(posedge clk);
      while (!(rsp_valid && rsp_ready)) @(posedge clk);
      taken++;
      @(negedge clk);
    end
  end

  initial begin : stimulus
    req_t directed[$];
    req_t r;

    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: field extremes for each op, equal and reversed subtraction,
    // zero divisor (also 0/0), exact and inexact divides.
    directed.push_back(make_req(OP_ADD, 32'h0000_0000, 32'h0000_0000));
    directed.push_back(make_req(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    directed.push_back(make_req(OP_ADD, 32'h8000_0000, 32'h8000_0000));
    directed.push_back(make_req(OP_SUB, 32'h0000_0005, 32'h0000_0005));
    directed.push_back(make_req(OP_SUB, 32'h0000_0003, 32'h0000_0007));
    directed.push_back(make_req(OP_SUB, 32'h0000_0000, 32'hFFFF_FFFF));
    directed.push_back(make_req(OP_SUB, 32'hFFFF_FFFF, 32'h0000_0000));
    directed.push_back(make_req(OP_SUB, 32'hFFFF_FFFF, 32'hFFFF_FFFE));
    directed.push_back(make_req(OP_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    directed.push_back(make_req(OP_MUL, 32'h0000_0000, 32'hFFFF_FFFF));
    directed.push_back(make_req(OP_MUL, 32'h0000_0001, 32'hDEAD_BEEF));
    directed.push_back(make_req(OP_MUL, 32'h0001_0000, 32'h0001_0000));
    directed.push_back(make_req(OP_DIV, 32'h0000_0000, 32'h0000_0000));
    directed.push_back(make_req(OP_DIV, 32'h0001_2345, 32'h0000_0000));
    directed.push_back(make_req(OP_DIV, 32'hFFFF_FFFF, 32'h0000_0001));
    directed.push_back(make_req(OP_DIV, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    directed.push_back(make_req(OP_DIV, 32'h0000_0000, 32'h0000_0007));
    directed.push_back(make_req(OP_DIV, 32'h0000_000A, 32'h0000_0003));
    directed.push_back(make_req(OP_DIV, 32'h0000_0001, 32'hFFFF_FFFF));
    directed.push_back(make_req(OP_DIV, 32'hFFFF_FFFE, 32'h0000_0002));
    directed.push_back(make_req(OP_DIV, 32'hFFFF_FFFF, 32'h0000_0003));
    directed.push_back(make_req(OP_DIV, 32'hFFFF_FFFF, 32'h0000_0002));
    foreach (directed[i]) offer_request(directed[i]);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 100 == 0)
        send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
      // back-pressure window: sink holds off while the sender streams
      if (i == HOLD_FIRST) hold_wanted = 1'b1;
      if (i >= HOLD_FIRST && i < HOLD_LAST) send_gap_max = 0;
      r = random_req();
      offer_request(r);
    end
    req_valid <= 1'b0;

    // drain, then give stray results time to show up
    do @(negedge clk); while (results_owed != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (bad_results == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: ends the run as failed if the stimulus has not finished first.
  initial begin : watchdog
    #3_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

/* four_op_unsigned_alu_core.f */
hw/rtl/alu4_pkg.sv
hw/rtl/alu4_front.sv
hw/rtl/alu4_queue.sv
hw/rtl/alu4_back.sv
hw/rtl/four_op_unsigned_alu_core.sv
sim/alu4_result_checker.sv
sim/four_op_unsigned_alu_core_tb.sv
